// ----- rtl/core/tfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared widths, payload types and fixed-point constants of the trajectory
// feasibility penalty core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfp_pkg;

  // fraction bits of the incoming coordinates
  localparam int COORD_FRAC_BITS = 16;
  // shift that widens a coordinate difference to Q32.32
  localparam int MAG_SHIFT       = 32 - COORD_FRAC_BITS;

  localparam int COORD_W    = 32;
  localparam int GRAD_W     = 64;
  localparam int COST_W     = 63;
  localparam int Q_W        = 64;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [GRAD_W-1:0]  grad_t;
  typedef logic        [COST_W-1:0]  cost_t;
  typedef logic        [Q_W-1:0]     q_t;

endpackage

// ----- rtl/core/tfp_ifs.sv -----
// ----------------------------------------------------------------------------
// tfp_ifs
// Valid/ready channels of the core: control points in, point gradients out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tfp_point_if import tfp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   final_point;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output final_point, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input final_point, output ready);
endinterface

interface tfp_grad_if import tfp_pkg::*; ();
  logic  valid;
  logic  ready;
  grad_t grad_x;
  grad_t grad_y;
  grad_t grad_z;
  cost_t total_cost;
  logic  last_result;

  modport source (output valid, output grad_x, output grad_y, output grad_z,
                  output total_cost, output last_result, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input grad_z,
                  input total_cost, input last_result, output ready);
endinterface

// ----- rtl/core/tfp_mulq.sv -----
// ----------------------------------------------------------------------------
// tfp_mulq
// Shared Q32.32 unsigned multiplier: one 32x32 product a cycle, four partial
// products accumulated, result truncated and saturated to 2^64-1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tfp_mulq import tfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  q_t   a,
  input  q_t   b,
  output logic busy,
  output logic done,
  output q_t   result
);

  localparam logic [2:0] PH_LL = 3'd0;
  localparam logic [2:0] PH_HL = 3'd1;
  localparam logic [2:0] PH_LH = 3'd2;
  localparam logic [2:0] PH_HH = 3'd3;
  localparam logic [2:0] PH_FIN = 3'd4;

  q_t          a_q;
  q_t          b_q;
  logic [2:0]  phase;
  logic        running;
  q_t          prod;
  logic [65:0] acc;
  logic        sat;
  logic [31:0] op_x;
  logic [31:0] op_y;
  q_t          mul_out;

  // phase bit 0 picks the high half of a, bit 1 the high half of b
  assign op_x    = phase[0] ? a_q[63:32] : a_q[31:0];
  assign op_y    = phase[1] ? b_q[63:32] : b_q[31:0];
  assign mul_out = {32'd0, op_x} * {32'd0, op_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase   <= PH_LL;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        phase   <= PH_LL;
      end else if (running) begin
        phase <= phase + 3'd1;
        if (phase == PH_FIN) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    if (running) begin
      prod <= mul_out;
      case (phase)
        PH_HL: begin
          acc <= {34'd0, prod[63:32]};
          sat <= 1'b0;
        end
        PH_LH, PH_HH: acc <= acc + {2'b00, prod};
        PH_FIN: begin
          acc <= acc + {2'b00, prod[31:0], 32'd0};
          sat <= (prod[63:32] != 32'd0);
        end
        default: ;
      endcase
    end
  end

  assign busy   = running;
  assign result = (sat || acc[65:64] != 2'b00) ? '1 : acc[63:0];

endmodule

// ----- rtl/core/trajectory_feasibility_penalty_core.sv -----
// ----------------------------------------------------------------------------
// trajectory_feasibility_penalty_core
// Velocity and acceleration feasibility penalty over a stream of Q16.16
// control points. For each axis in use, squared velocity and acceleration
// from the first and second differences are checked against the squared
// limits; an excess adds its square to the cost and a gradient to the points
// involved. A point's gradient goes out once two later points are in, the
// final point flushes the rest and carries the total cost. All products
// run on one shared 32x32 multiplier under a sequencer, so one item is
// in the block at a time: each item first forms the squared limits and
// 1/ts^4, then per difference term (up to six terms) a Q32.32 square and
// scaling, and when over the limit also the cost and gradient products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trajectory_feasibility_penalty_core import tfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  tfp_point_if.sink             points,
  tfp_grad_if.source            gradients
);

  localparam logic [1:0] REG_INV  = 2'd0;
  localparam logic [1:0] REG_VLIM = 2'd1;
  localparam logic [1:0] REG_ALIM = 2'd2;
  localparam logic [1:0] REG_AXES = 2'd3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ISSUE = 4'd1;
  localparam logic [3:0] S_WAIT  = 4'd2;
  localparam logic [3:0] S_AXIS  = 4'd3;
  localparam logic [3:0] S_MAG   = 4'd4;
  localparam logic [3:0] S_PUSH  = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [2:0] OP_S4  = 3'd0;
  localparam logic [2:0] OP_VM2 = 3'd1;
  localparam logic [2:0] OP_AM2 = 3'd2;
  localparam logic [2:0] OP_SQ  = 3'd3;
  localparam logic [2:0] OP_SCL = 3'd4;
  localparam logic [2:0] OP_DD  = 3'd5;
  localparam logic [2:0] OP_DS  = 3'd6;
  localparam logic [2:0] OP_DM  = 3'd7;

  localparam cost_t COST_CAP = '1;

  // configuration
  logic [31:0] inv_interval_sq;
  logic [31:0] velocity_limit;
  logic [31:0] acceleration_limit;
  logic [1:0]  axes_used;
  logic        cfg_wr;

  // sequencer and working registers
  logic [3:0]  state;
  logic [2:0]  op;
  logic [1:0]  axis;
  logic        is_acc;
  logic [1:0]  emit_k;
  coord_t      pt [3];
  logic        fin;
  q_t          s4;
  q_t          vm2;
  q_t          am2;
  q_t          mag;
  logic        neg;
  q_t          work;
  q_t          dreg;

  // trajectory state
  coord_t      r0 [3];
  coord_t      r1 [3];
  grad_t       pg [3][3];
  cost_t       cost_sum;
  logic [1:0]  points_seen;

  // output register
  logic        res_valid;
  grad_t       res_gx;
  grad_t       res_gy;
  grad_t       res_gz;
  cost_t       res_cost;
  logic        res_last;
  logic        out_free;

  // shared multiplier
  logic        mul_start;
  q_t          mul_a;
  q_t          mul_b;
  logic        mul_busy;
  logic        mul_done;
  q_t          mul_result;

  q_t          s2;
  q_t          scale;
  q_t          lim2;
  q_t          mag_next;
  logic [34:0] pe;
  logic [34:0] r1e;
  logic [34:0] r0e;
  logic [34:0] diff;
  logic [34:0] absd;
  logic [1:0]  s_minus1;
  logic        push_en [3];
  grad_t       push_val [3];
  logic        emit_last;
  logic        emit_done;

  function automatic cost_t cost_add(cost_t c, q_t t);
    logic [64:0] sum;
    sum = {2'b00, c} + {1'b0, t};
    return (sum >= {2'b00, COST_CAP}) ? COST_CAP : sum[62:0];
  endfunction

  // add a signed term, magnitude clamped to 2^63-1, with signed saturation
  function automatic grad_t sat_push(grad_t g, q_t m, logic ng);
    logic [62:0] v;
    logic [64:0] ext_g;
    logic [64:0] sum;
    grad_t       res;
    v     = m[63] ? '1 : m[62:0];
    ext_g = {g[63], g};
    sum   = ng ? ext_g - {2'b00, v} : ext_g + {2'b00, v};
    if (sum[64] != sum[63]) begin
      res = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      res = sum[63:0];
    end
    return res;
  endfunction

  tfp_mulq u_mulq (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_result)
  );

  // -------------------------------------------------------------------------
  // configuration port
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_interval_sq    <= 32'd65536;
      velocity_limit     <= 32'd196608;
      acceleration_limit <= 32'd131072;
      axes_used          <= 2'd3;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INV:  inv_interval_sq    <= pwdata;
        REG_VLIM: velocity_limit     <= pwdata;
        REG_ALIM: acceleration_limit <= pwdata;
        REG_AXES: axes_used          <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INV:  prdata = inv_interval_sq;
      REG_VLIM: prdata = velocity_limit;
      REG_ALIM: prdata = acceleration_limit;
      REG_AXES: prdata = {30'd0, axes_used};
      default:  prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // datapath selection
  // -------------------------------------------------------------------------
  assign s2    = {16'd0, inv_interval_sq, 16'd0};
  assign scale = is_acc ? s4 : s2;
  assign lim2  = is_acc ? am2 : vm2;

  always_comb begin
    case (op)
      OP_S4:   begin mul_a = {inv_interval_sq, 32'd0};    mul_b = {32'd0, inv_interval_sq};    end
      OP_VM2:  begin mul_a = {velocity_limit, 32'd0};     mul_b = {32'd0, velocity_limit};     end
      OP_AM2:  begin mul_a = {acceleration_limit, 32'd0}; mul_b = {32'd0, acceleration_limit}; end
      OP_SQ:   begin mul_a = mag;  mul_b = mag;   end
      OP_SCL:  begin mul_a = work; mul_b = scale; end
      OP_DD:   begin mul_a = dreg; mul_b = dreg;  end
      OP_DS:   begin mul_a = dreg; mul_b = scale; end
      OP_DM:   begin mul_a = work; mul_b = mag;   end
      default: begin mul_a = mag;  mul_b = mag;   end
    endcase
  end

  assign mul_start = (state == S_ISSUE);

  // magnitude and sign of the first or second difference of the current axis, magnitude widened to Q32.32
  always_comb begin
    pe   = {{3{pt[axis][31]}}, pt[axis]};
    r1e  = {{3{r1[axis][31]}}, r1[axis]};
    r0e  = {{3{r0[axis][31]}}, r0[axis]};
    diff = is_acc ? pe - {r1e[33:0], 1'b0} + r0e : pe - r1e;
    absd = diff[34] ? 35'd0 - diff : diff;
    mag_next = 64'(absd) << MAG_SHIFT;
  end

  assign s_minus1 = points_seen - 2'd1;

  // velocity: earlier point gets the opposite sign; acceleration: +t, -2t, +t
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (is_acc) begin
        push_en[k]  = 1'b1;
        push_val[k] = (k == 1) ?
                      sat_push(pg[k][axis], work[63] ? '1 : {work[62:0], 1'b0}, !neg) :
                      sat_push(pg[k][axis], work, neg);
      end else begin
        push_en[k]  = (2'(k) == points_seen) || (2'(k) == s_minus1);
        push_val[k] = sat_push(pg[k][axis], work,
                               (2'(k) == points_seen) ? neg : !neg);
      end
    end
  end

  assign out_free  = !res_valid || gradients.ready;
  assign emit_last = fin && (emit_k == points_seen);
  assign emit_done = fin ? emit_last : 1'b1;

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_S4;
      axis        <= 2'd0;
      is_acc      <= 1'b0;
      emit_k      <= 2'd0;
      res_valid   <= 1'b0;
      cost_sum    <= '0;
      points_seen <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        r0[i] <= '0;
        r1[i] <= '0;
        for (int j = 0; j < 3; j++) pg[i][j] <= '0;
      end
    end else begin
      if (state == S_EMIT && out_free) res_valid <= 1'b1;
      else if (gradients.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (points.valid) begin
            pt[0]  <= points.pos_x;
            pt[1]  <= points.pos_y;
            pt[2]  <= points.pos_z;
            fin    <= points.final_point;
            op     <= OP_S4;
            axis   <= 2'd0;
            is_acc <= 1'b0;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            case (op)
              OP_S4: begin
                s4    <= mul_result;
                op    <= OP_VM2;
                state <= S_ISSUE;
              end
              OP_VM2: begin
                vm2   <= mul_result;
                op    <= OP_AM2;
                state <= S_ISSUE;
              end
              OP_AM2: begin
                am2   <= mul_result;
                state <= S_AXIS;
              end
              OP_SQ: begin
                work  <= mul_result;
                op    <= OP_SCL;
                state <= S_ISSUE;
              end
              OP_SCL: begin
                // within the limit: no cost, no gradient
                if (mul_result <= lim2) begin
                  state <= S_NEXT;
                end else begin
                  dreg  <= mul_result - lim2;
                  op    <= OP_DD;
                  state <= S_ISSUE;
                end
              end
              OP_DD: begin
                cost_sum <= cost_add(cost_sum, mul_result);
                op       <= OP_DS;
                state    <= S_ISSUE;
              end
              OP_DS: begin
                work  <= mul_result;
                op    <= OP_DM;
                state <= S_ISSUE;
              end
              OP_DM: begin
                work  <= (mul_result[63:62] != 2'b00) ? '1 : {mul_result[61:0], 2'b00};
                state <= S_PUSH;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_AXIS: begin
          if (points_seen != 2'd0 && axis < axes_used) state <= S_MAG;
          else state <= S_END;
        end
        S_MAG: begin
          mag   <= mag_next;
          neg   <= diff[34];
          op    <= OP_SQ;
          state <= S_ISSUE;
        end
        S_PUSH: begin
          for (int k = 0; k < 3; k++) begin
            if (push_en[k]) pg[k][axis] <= push_val[k];
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (!is_acc && points_seen == 2'd2) begin
            is_acc <= 1'b1;
            state  <= S_MAG;
          end else begin
            axis   <= axis + 2'd1;
            is_acc <= 1'b0;
            state  <= S_AXIS;
          end
        end
        S_END: begin
          emit_k <= 2'd0;
          if (fin || points_seen == 2'd2) state <= S_EMIT;
          else state <= S_FIN;
        end
        S_EMIT: begin
          if (out_free) begin
            res_gx    <= pg[emit_k][0];
            res_gy    <= pg[emit_k][1];
            res_gz    <= pg[emit_k][2];
            res_cost  <= emit_last ? cost_sum : '0;
            res_last  <= emit_last;
            if (emit_done) state <= S_FIN;
            else emit_k <= emit_k + 2'd1;
          end
        end
        S_FIN: begin
          if (fin) begin
            // end of trajectory: back to the empty state
            cost_sum    <= '0;
            points_seen <= 2'd0;
            for (int i = 0; i < 3; i++) begin
              r0[i] <= '0;
              r1[i] <= '0;
              for (int j = 0; j < 3; j++) pg[i][j] <= '0;
            end
          end else begin
            if (points_seen == 2'd2) begin
              for (int j = 0; j < 3; j++) begin
                pg[0][j] <= pg[1][j];
                pg[1][j] <= pg[2][j];
                pg[2][j] <= '0;
              end
            end else begin
              points_seen <= points_seen + 2'd1;
            end
            for (int i = 0; i < 3; i++) begin
              r0[i] <= r1[i];
              r1[i] <= pt[i];
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign points.ready          = (state == S_IDLE);
  assign gradients.valid       = res_valid;
  assign gradients.grad_x      = res_gx;
  assign gradients.grad_y      = res_gy;
  assign gradients.grad_z      = res_gz;
  assign gradients.total_cost  = res_cost;
  assign gradients.last_result = res_last;

`ifndef SYNTH
  // the multiplier is only started when it is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // a finished product is always picked up by the sequencer
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_WAIT)
    else $error("product finished outside the wait state");

  // cost travels only with the last result of a trajectory
  a_cost_last: assert property (@(posedge clk) disable iff (rst)
    gradients.valid && !gradients.last_result |-> gradients.total_cost == '0)
    else $error("cost on a result that is not the last");

  // the final point leaves the trajectory state empty
  a_fin_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && fin |=> points_seen == 2'd0 && cost_sum == '0)
    else $error("trajectory state not cleared after the final point");
`endif

endmodule
